### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the svpwm rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// widths, constants, shared types and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

    localparam int VOLT_WIDTH     = 16;
    localparam int ANGLE_WIDTH    = 16;
    localparam int DUTY_FRAC_BITS = 15;
    localparam int DUTY_WIDTH     = DUTY_FRAC_BITS + 1;
    localparam int VOLT_FRAC_BITS = 6;
    localparam int LIMIT_WIDTH    = 16;
    localparam int SCALE_WIDTH    = 16;
    localparam int SCALE_BITS     = 15;
    localparam int GUARD          = 12;
    localparam int GAIN_SHIFT     = 20 - GUARD;
    localparam int CORDIC_STEPS   = 24;
    localparam int ZW             = 32;
    localparam int XW             = 30;
    localparam int PW             = 31;
    localparam int MW             = 30;
    localparam int NW             = LIMIT_WIDTH + VOLT_WIDTH + GUARD;
    localparam int SDIV_STEPS     = SCALE_BITS;
    localparam int DDIV_STEPS     = DUTY_FRAC_BITS + GUARD;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;

    localparam logic signed [20:0] GAIN_Q20       = 21'sd636751;
    localparam logic signed [17:0] HALF_SQRT3_Q16 = 18'sd56756;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd18919;
    localparam logic [SCALE_WIDTH-1:0] SCALE_ONE   = 16'd32768;
    localparam logic [DUTY_WIDTH-1:0]  DUTY_HALF   = DUTY_WIDTH'(1) << (DUTY_FRAC_BITS - 1);
    localparam logic [DUTY_WIDTH-1:0]  DUTY_FULL   = DUTY_WIDTH'(1) << DUTY_FRAC_BITS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [VOLT_WIDTH-1:0] vdc;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
        logic [1:0]            quad;
    } svpwm_item_t;

    function automatic logic signed [ZW-1:0] atan_turns(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_turns = 32'sd536870912;
            5'd1:    atan_turns = 32'sd316933406;
            5'd2:    atan_turns = 32'sd167458907;
            5'd3:    atan_turns = 32'sd85004756;
            5'd4:    atan_turns = 32'sd42667331;
            5'd5:    atan_turns = 32'sd21354465;
            5'd6:    atan_turns = 32'sd10679838;
            5'd7:    atan_turns = 32'sd5340245;
            5'd8:    atan_turns = 32'sd2670163;
            5'd9:    atan_turns = 32'sd1335087;
            5'd10:   atan_turns = 32'sd667544;
            5'd11:   atan_turns = 32'sd333772;
            5'd12:   atan_turns = 32'sd166886;
            5'd13:   atan_turns = 32'sd83443;
            5'd14:   atan_turns = 32'sd41722;
            5'd15:   atan_turns = 32'sd20861;
            5'd16:   atan_turns = 32'sd10430;
            5'd17:   atan_turns = 32'sd5215;
            5'd18:   atan_turns = 32'sd2608;
            5'd19:   atan_turns = 32'sd1304;
            5'd20:   atan_turns = 32'sd652;
            5'd21:   atan_turns = 32'sd326;
            5'd22:   atan_turns = 32'sd163;
            5'd23:   atan_turns = 32'sd81;
            default: atan_turns = 32'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### hw/rtl/svpwm_front.sv
// ----------------------------------------------------------------------------
// svpwm_front
// input stage: bus magnitude, gain-corrected d/q and quadrant split of angle
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_front (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  logic signed [svpwm_pkg::VOLT_WIDTH-1:0]      s_bus_voltage,
    input  logic signed [svpwm_pkg::VOLT_WIDTH-1:0]      s_d_voltage_ref,
    input  logic signed [svpwm_pkg::VOLT_WIDTH-1:0]      s_q_voltage_ref,
    input  logic [svpwm_pkg::ANGLE_WIDTH-1:0]            s_electrical_angle,
    output svpwm_pkg::svpwm_item_t                       item,
    output logic                                         item_valid,
    input  logic                                         item_ready
);

    localparam int VW = svpwm_pkg::VOLT_WIDTH;
    localparam int AW = svpwm_pkg::ANGLE_WIDTH;
    localparam int XW = svpwm_pkg::XW;
    localparam int ZW = svpwm_pkg::ZW;
    localparam logic [VW-1:0] VMIN = VW'(1) << svpwm_pkg::VOLT_FRAC_BITS;

    logic [VW-1:0]          vabs;
    logic [VW-1:0]          vdc;
    logic signed [VW+20:0]  prod_d;
    logic signed [VW+20:0]  prod_q;
    logic [ZW-1:0]          p;
    logic [ZW-1:0]          psum;
    logic [ZW-1:0]          u;
    logic                   accept;
    svpwm_pkg::svpwm_item_t item_reg;
    svpwm_pkg::svpwm_item_t item_next;
    logic                   valid_reg;
    logic                   valid_next;

    assign vabs = s_bus_voltage[VW-1] ? VW'(-s_bus_voltage) : VW'(s_bus_voltage);
    assign vdc  = (vabs < VMIN) ? VMIN : vabs;

    assign prod_d = s_d_voltage_ref * svpwm_pkg::GAIN_Q20;
    assign prod_q = s_q_voltage_ref * svpwm_pkg::GAIN_Q20;

    // angle as 32-bit turns, nearest quarter turn split off
    assign p    = {s_electrical_angle, {(ZW-AW){1'b0}}};
    assign psum = p + 32'h2000_0000;
    assign u    = p - {psum[ZW-1:ZW-2], {(ZW-2){1'b0}}};

    always_comb begin
        item_next.vdc  = vdc;
        item_next.x    = XW'(prod_d >>> svpwm_pkg::GAIN_SHIFT);
        item_next.y    = XW'(prod_q >>> svpwm_pkg::GAIN_SHIFT);
        item_next.z    = signed'(u);
        item_next.quad = psum[ZW-1:ZW-2];
    end

    assign s_ready    = !valid_reg || item_ready;
    assign accept     = s_valid && s_ready;
    assign valid_next = accept || (valid_reg && !item_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

### hw/rtl/svpwm_queue.sv
// ----------------------------------------------------------------------------
// svpwm_queue
// short fifo between the front stage and the back pipeline
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module svpwm_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  svpwm_pkg::svpwm_item_t push_item,
    input  logic                   push_valid,
    output logic                   push_ready,
    output svpwm_pkg::svpwm_item_t pop_item,
    output logic                   pop_valid,
    input  logic                   pop_ready
);

    localparam int DEPTH = svpwm_pkg::QUEUE_DEPTH;
    localparam int AW    = svpwm_pkg::QUEUE_AW;

    svpwm_pkg::svpwm_item_t mem_reg [DEPTH];
    logic [AW-1:0]          wr_ptr_reg;
    logic [AW-1:0]          wr_ptr_next;
    logic [AW-1:0]          rd_ptr_reg;
    logic [AW-1:0]          rd_ptr_next;
    logic [AW:0]            count_reg;
    logic [AW:0]            count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1, count_reg <= (AW+1)'(DEPTH))
    `ASSERT_NEXT(a_count_both, aclk, aresetn, push && pop, $stable(count_reg))

endmodule

`default_nettype wire

### hw/rtl/svpwm_back.sv
// ----------------------------------------------------------------------------
// svpwm_back
// cordic inverse park, min-max injection, scale divider and duty dividers
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module svpwm_back (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  svpwm_pkg::svpwm_item_t                   pop_item,
    input  logic                                     pop_valid,
    output logic                                     pop_ready,
    input  logic [svpwm_pkg::LIMIT_WIDTH-1:0]        peak_limit,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [svpwm_pkg::DUTY_WIDTH-1:0]         m_duty_a,
    output logic [svpwm_pkg::DUTY_WIDTH-1:0]         m_duty_b,
    output logic [svpwm_pkg::DUTY_WIDTH-1:0]         m_duty_c,
    output logic [svpwm_pkg::SCALE_WIDTH-1:0]        m_phase_gain
);

    localparam int VW    = svpwm_pkg::VOLT_WIDTH;
    localparam int XW    = svpwm_pkg::XW;
    localparam int ZW    = svpwm_pkg::ZW;
    localparam int PW    = svpwm_pkg::PW;
    localparam int MW    = svpwm_pkg::MW;
    localparam int NW    = svpwm_pkg::NW;
    localparam int DW    = svpwm_pkg::DUTY_WIDTH;
    localparam int SW    = svpwm_pkg::SCALE_WIDTH;
    localparam int SB    = svpwm_pkg::SCALE_BITS;
    localparam int GD    = svpwm_pkg::GUARD;
    localparam int NC    = svpwm_pkg::CORDIC_STEPS;
    localparam int NS    = svpwm_pkg::SDIV_STEPS;
    localparam int ND    = svpwm_pkg::DDIV_STEPS;
    localparam int LW    = svpwm_pkg::LIMIT_WIDTH;
    localparam int NSTG  = NC + NS + ND + 7;

    typedef struct packed {
        logic signed [PW-1:0] ca;
        logic signed [PW-1:0] cb;
        logic signed [PW-1:0] cc;
        logic [VW-1:0]        vdc;
    } back_cmd_t;

    function automatic logic [MW-1:0] mag_of(input logic signed [PW-1:0] v);
        mag_of = v[PW-1] ? MW'(-v) : MW'(v);
    endfunction

    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    assign en        = !m_valid || m_ready;
    assign pop_ready = en;
    assign vld_next  = {vld_reg[NSTG-2:0], pop_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // cordic rotation
    logic signed [XW-1:0] cx_reg   [NC+1];
    logic signed [XW-1:0] cy_reg   [NC+1];
    logic signed [ZW-1:0] cz_reg   [NC+1];
    logic [VW-1:0]        cvdc_reg [NC+1];
    logic signed [XW-1:0] rot_x;
    logic signed [XW-1:0] rot_y;

    always_comb begin
        case (pop_item.quad)
            svpwm_pkg::QUAD_1: begin
                rot_x = -pop_item.y;
                rot_y = pop_item.x;
            end
            svpwm_pkg::QUAD_2: begin
                rot_x = -pop_item.x;
                rot_y = -pop_item.y;
            end
            svpwm_pkg::QUAD_3: begin
                rot_x = pop_item.y;
                rot_y = -pop_item.x;
            end
            default: begin
                rot_x = pop_item.x;
                rot_y = pop_item.y;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0]   <= rot_x;
            cy_reg[0]   <= rot_y;
            cz_reg[0]   <= pop_item.z;
            cvdc_reg[0] <= pop_item.vdc;
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;

        assign dx = cy_reg[k] >>> k;
        assign dy = cx_reg[k] >>> k;
        assign at = svpwm_pkg::atan_turns(5'(k));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!cz_reg[k][ZW-1]) begin
                    cx_reg[k+1] <= cx_reg[k] - dx;
                    cy_reg[k+1] <= cy_reg[k] + dy;
                    cz_reg[k+1] <= cz_reg[k] - at;
                end else begin
                    cx_reg[k+1] <= cx_reg[k] + dx;
                    cy_reg[k+1] <= cy_reg[k] - dy;
                    cz_reg[k+1] <= cz_reg[k] + at;
                end
                cvdc_reg[k+1] <= cvdc_reg[k];
            end
        end
    end

    // beta times sqrt3/2
    logic signed [XW+17:0] b_prod;
    logic signed [PW-1:0]  b_x_reg;
    logic signed [PW-1:0]  b_s_reg;
    logic [VW-1:0]         b_vdc_reg;

    assign b_prod = cy_reg[NC] * svpwm_pkg::HALF_SQRT3_Q16;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_x_reg   <= PW'(cx_reg[NC]);
            b_s_reg   <= PW'(b_prod >>> 16);
            b_vdc_reg <= cvdc_reg[NC];
        end
    end

    // three phase references and the scale numerator
    logic signed [PW-1:0] c_hf;
    logic [LW+VW-1:0]     c_lv;
    logic signed [PW-1:0] c_ra_reg;
    logic signed [PW-1:0] c_rb_reg;
    logic signed [PW-1:0] c_rc_reg;
    logic [VW-1:0]        c_vdc_reg;
    logic [NW-1:0]        c_num_reg;

    assign c_hf = b_x_reg >>> 1;
    assign c_lv = (LW+VW)'(peak_limit) * (LW+VW)'(b_vdc_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            c_ra_reg  <= b_x_reg;
            c_rb_reg  <= b_s_reg - c_hf;
            c_rc_reg  <= -c_hf - b_s_reg;
            c_vdc_reg <= b_vdc_reg;
            c_num_reg <= NW'(c_lv) << GD;
        end
    end

    // min-max offset
    logic signed [PW-1:0] d_mx;
    logic signed [PW-1:0] d_mn;
    logic signed [PW:0]   d_sum;
    logic signed [PW:0]   d_off;
    back_cmd_t            d_cmd_reg;
    logic [NW-1:0]        d_num_reg;

    always_comb begin
        d_mx = c_ra_reg;
        if (c_rb_reg > d_mx) d_mx = c_rb_reg;
        if (c_rc_reg > d_mx) d_mx = c_rc_reg;
        d_mn = c_ra_reg;
        if (c_rb_reg < d_mn) d_mn = c_rb_reg;
        if (c_rc_reg < d_mn) d_mn = c_rc_reg;
        d_sum = (PW+1)'(d_mx) + (PW+1)'(d_mn);
        d_off = -(d_sum >>> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_cmd_reg.ca  <= PW'((PW+1)'(c_ra_reg) + d_off);
            d_cmd_reg.cb  <= PW'((PW+1)'(c_rb_reg) + d_off);
            d_cmd_reg.cc  <= PW'((PW+1)'(c_rc_reg) + d_off);
            d_cmd_reg.vdc <= c_vdc_reg;
            d_num_reg     <= c_num_reg;
        end
    end

    // scale divider: num / maxabs, one quotient bit per stage
    logic [MW-1:0] e_ma;
    logic [MW-1:0] e_mb;
    logic [MW-1:0] e_mc;
    logic [MW-1:0] e_max;
    logic [MW-1:0] e_den;

    logic [MW-1:0] f_rem_reg [NS+1];
    logic [SB-1:0] f_q_reg   [NS+1];
    logic [SB-1:0] f_low_reg [NS+1];
    logic [MW-1:0] f_den_reg [NS+1];
    logic          f_sat_reg [NS+1];
    back_cmd_t     f_cmd_reg [NS+1];

    always_comb begin
        e_ma  = mag_of(d_cmd_reg.ca);
        e_mb  = mag_of(d_cmd_reg.cb);
        e_mc  = mag_of(d_cmd_reg.cc);
        e_max = e_ma;
        if (e_mb > e_max) e_max = e_mb;
        if (e_mc > e_max) e_max = e_mc;
        e_den = (e_max == '0) ? MW'(1) : e_max;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_rem_reg[0] <= MW'(d_num_reg[NW-1:SB]);
            f_q_reg[0]   <= '0;
            f_low_reg[0] <= d_num_reg[SB-1:0];
            f_den_reg[0] <= e_den;
            f_sat_reg[0] <= ((NW+1)'(d_num_reg) >= {e_den, {SB{1'b0}}});
            f_cmd_reg[0] <= d_cmd_reg;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_sdiv
        logic [MW:0] trial;
        logic        ge;

        assign trial = {f_rem_reg[j], f_low_reg[j][SB-1]};
        assign ge    = trial >= {1'b0, f_den_reg[j]};

        always_ff @(posedge aclk) begin
            if (en) begin
                f_rem_reg[j+1] <= ge ? MW'(trial - {1'b0, f_den_reg[j]}) : MW'(trial);
                f_q_reg[j+1]   <= {f_q_reg[j][SB-2:0], ge};
                f_low_reg[j+1] <= f_low_reg[j] << 1;
                f_den_reg[j+1] <= f_den_reg[j];
                f_sat_reg[j+1] <= f_sat_reg[j];
                f_cmd_reg[j+1] <= f_cmd_reg[j];
            end
        end
    end

    // apply scale to the three commands
    logic [SW-1:0]          g_scale;
    logic signed [PW+SW:0]  g_prod [3];
    logic signed [PW-1:0]   g_sc_reg [3];
    logic [VW-1:0]          g_vdc_reg;
    logic [SW-1:0]          g_scale_reg;

    assign g_scale   = f_sat_reg[NS] ? svpwm_pkg::SCALE_ONE : {1'b0, f_q_reg[NS]};
    assign g_prod[0] = f_cmd_reg[NS].ca * signed'({1'b0, g_scale});
    assign g_prod[1] = f_cmd_reg[NS].cb * signed'({1'b0, g_scale});
    assign g_prod[2] = f_cmd_reg[NS].cc * signed'({1'b0, g_scale});

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                g_sc_reg[i] <= PW'(g_prod[i] >>> SB);
            end
            g_vdc_reg   <= f_cmd_reg[NS].vdc;
            g_scale_reg <= g_scale;
        end
    end

    // duty dividers: |cmd| * 2^frac / vdc, one bit per stage
    logic [VW-1:0] dd_rem_reg [ND+1][3];
    logic [ND-1:0] dd_q_reg   [ND+1][3];
    logic [ND-1:0] dd_low_reg [ND+1][3];
    logic          dd_sat_reg [ND+1][3];
    logic          dd_neg_reg [ND+1][3];
    logic [VW-1:0] dd_vdc_reg [ND+1];
    logic [SW-1:0] dd_scl_reg [ND+1];

    for (genvar i = 0; i < 3; i++) begin : g_dd_in
        logic [MW-1:0] m;

        assign m = mag_of(g_sc_reg[i]);

        always_ff @(posedge aclk) begin
            if (en) begin
                dd_rem_reg[0][i] <= m[GD+VW-1:GD];
                dd_q_reg[0][i]   <= '0;
                dd_low_reg[0][i] <= {m[GD-1:0], {svpwm_pkg::DUTY_FRAC_BITS{1'b0}}};
                dd_sat_reg[0][i] <= (m[MW-1:GD] >= (MW-GD)'(g_vdc_reg));
                dd_neg_reg[0][i] <= g_sc_reg[i][PW-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_vdc_reg[0] <= g_vdc_reg;
            dd_scl_reg[0] <= g_scale_reg;
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_ddiv
        for (genvar i = 0; i < 3; i++) begin : g_ph
            logic [VW:0] trial;
            logic        ge;

            assign trial = {dd_rem_reg[j][i], dd_low_reg[j][i][ND-1]};
            assign ge    = trial >= {1'b0, dd_vdc_reg[j]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    dd_rem_reg[j+1][i] <= ge ? VW'(trial - {1'b0, dd_vdc_reg[j]}) : VW'(trial);
                    dd_q_reg[j+1][i]   <= {dd_q_reg[j][i][ND-2:0], ge};
                    dd_low_reg[j+1][i] <= dd_low_reg[j][i] << 1;
                    dd_sat_reg[j+1][i] <= dd_sat_reg[j][i];
                    dd_neg_reg[j+1][i] <= dd_neg_reg[j][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dd_vdc_reg[j+1] <= dd_vdc_reg[j];
                dd_scl_reg[j+1] <= dd_scl_reg[j];
            end
        end
    end

    // rounding, offset by one half and clamp
    logic [DW-1:0] duty_next [3];
    logic [DW-1:0] duty_reg  [3];
    logic [SW-1:0] scale_reg;
    logic          m_valid_reg;
    logic          duty_in_range;

    for (genvar i = 0; i < 3; i++) begin : g_duty
        logic [ND:0]   qr;
        logic [DW-1:0] r;
        logic [DW:0]   up;

        assign qr = (ND+1)'(dd_q_reg[ND][i]) + ((ND+1)'(1) << (GD - 1));
        assign r  = qr[ND:GD];
        assign up = (DW+1)'(svpwm_pkg::DUTY_HALF) + (DW+1)'(r);

        always_comb begin
            if (dd_sat_reg[ND][i]) begin
                duty_next[i] = dd_neg_reg[ND][i] ? '0 : svpwm_pkg::DUTY_FULL;
            end else if (dd_neg_reg[ND][i]) begin
                duty_next[i] = (r >= svpwm_pkg::DUTY_HALF) ? '0 : svpwm_pkg::DUTY_HALF - r;
            end else begin
                duty_next[i] = (up > (DW+1)'(svpwm_pkg::DUTY_FULL)) ?
                               svpwm_pkg::DUTY_FULL : DW'(up);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                duty_reg[i] <= duty_next[i];
            end
            scale_reg <= dd_scl_reg[ND];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_duty_a     = duty_reg[0];
    assign m_duty_b     = duty_reg[1];
    assign m_duty_c     = duty_reg[2];
    assign m_phase_gain = scale_reg;

    assign duty_in_range = (duty_reg[0] <= svpwm_pkg::DUTY_FULL) &&
                           (duty_reg[1] <= svpwm_pkg::DUTY_FULL) &&
                           (duty_reg[2] <= svpwm_pkg::DUTY_FULL);

    `ASSERT_IMPL(a_scale_max, aclk, aresetn, m_valid_reg, scale_reg <= svpwm_pkg::SCALE_ONE)
    `ASSERT_IMPL(a_duty_max, aclk, aresetn, m_valid_reg, duty_in_range)
    `ASSERT_NEXT(a_drain, aclk, aresetn, m_ready && !vld_reg[NSTG-1], !m_valid_reg)

endmodule

`default_nettype wire

### hw/rtl/svpwm_duty_calculator.sv
// Space-vector PWM duty generator with min-max zero-sequence injection. It takes
// one beat per clock while the output is not stalled, and gives one result beat
// per input beat, in order. The arithmetic pipeline holds the 24-stage CORDIC
// rotator, the 15-stage restoring divider for the scale and the 27-stage
// restoring dividers for the duties. A four-entry queue sits between the input
// stage and the arithmetic pipeline. While a finished beat waits in the output
// register the whole arithmetic pipeline stalls, and the input stage and queue
// take up to five more beats before s_ready drops. peak_limit is written
// through cfg_we/cfg_wdata and must only change while the block is empty.
// ----------------------------------------------------------------------------
// svpwm_duty_calculator
// top level: configuration register, front stage, queue and back pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_duty_calculator (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic [svpwm_pkg::LIMIT_WIDTH-1:0]        cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [svpwm_pkg::VOLT_WIDTH-1:0]  s_bus_voltage,
    input  logic signed [svpwm_pkg::VOLT_WIDTH-1:0]  s_d_voltage_ref,
    input  logic signed [svpwm_pkg::VOLT_WIDTH-1:0]  s_q_voltage_ref,
    input  logic [svpwm_pkg::ANGLE_WIDTH-1:0]        s_electrical_angle,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [svpwm_pkg::DUTY_WIDTH-1:0]         m_duty_a,
    output logic [svpwm_pkg::DUTY_WIDTH-1:0]         m_duty_b,
    output logic [svpwm_pkg::DUTY_WIDTH-1:0]         m_duty_c,
    output logic [svpwm_pkg::SCALE_WIDTH-1:0]        m_phase_gain
);

    logic [svpwm_pkg::LIMIT_WIDTH-1:0] peak_limit_reg;
    svpwm_pkg::svpwm_item_t            front_item;
    logic                              front_valid;
    logic                              front_ready;
    svpwm_pkg::svpwm_item_t            queue_item;
    logic                              queue_valid;
    logic                              queue_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_limit_reg <= svpwm_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            peak_limit_reg <= cfg_wdata;
        end
    end

    svpwm_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_bus_voltage      (s_bus_voltage),
        .s_d_voltage_ref    (s_d_voltage_ref),
        .s_q_voltage_ref    (s_q_voltage_ref),
        .s_electrical_angle (s_electrical_angle),
        .item               (front_item),
        .item_valid         (front_valid),
        .item_ready         (front_ready)
    );

    svpwm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    svpwm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .pop_item           (queue_item),
        .pop_valid          (queue_valid),
        .pop_ready          (queue_ready),
        .peak_limit         (peak_limit_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_duty_a           (m_duty_a),
        .m_duty_b           (m_duty_b),
        .m_duty_c           (m_duty_c),
        .m_phase_gain       (m_phase_gain)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm duty calculator testbench
// drives voltage and angle beats with random gaps and output stalls, predicts
// the duties and scale of each beat and checks every result beat in order,
// over several peak limit settings
// ----------------------------------------------------------------------------

class duty_scoreboard;

    typedef struct {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [15:0] scale;
    } duty_beat_t;

    duty_beat_t  pending_duties[$];
    logic [15:0] limit;
    int          errors;
    int          checked;
    longint      turn_table[24];

    function new();
        limit  = 16'd18919;
        errors = 0;
        checked = 0;
        turn_table = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772,
                       166886, 83443, 41722, 20861, 10430, 5215,
                       2608, 1304, 652, 326, 163, 81};
    endfunction

    function longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function logic [15:0] phase_duty(longint cmd, longint scale, longint vdc);
        longint sc, m, q, r;
        sc = (cmd * scale) >>> 15;
        m  = magnitude(sc);
        q  = ((m / vdc) << 15) + (((m % vdc) << 15) / vdc);
        r  = (q + 2048) >>> 12;
        if (sc < 0)
            return (r >= 16384) ? 16'd0 : 16'(16384 - r);
        return (16384 + r > 32768) ? 16'd32768 : 16'(16384 + r);
    endfunction

    function void note_input(logic signed [15:0] bus, logic signed [15:0] d,
                             logic signed [15:0] q, logic [15:0] ang);
        longint     vdc, x, y, z, t, dx, dy, hf, s, ra, rb, rc, mx, mn, off;
        longint     ca, cb, cc, maxabs, num, scale;
        logic [31:0] p, u;
        logic [1:0] quad;
        duty_beat_t e;
        vdc = magnitude(longint'(bus));
        if (vdc < 64) vdc = 64;
        x = (longint'(d) * 636751) >>> 8;
        y = (longint'(q) * 636751) >>> 8;
        p = {ang, 16'h0000};
        quad = 2'((p + 32'h2000_0000) >> 30);
        u = p - ({30'd0, quad} << 30);
        z = longint'(signed'(u));
        for (int k = 0; k < quad; k++) begin
            t = x;
            x = -y;
            y = t;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= turn_table[i];
            end else begin
                x += dx; y -= dy; z += turn_table[i];
            end
        end
        hf = x >>> 1;
        s  = (y * 56756) >>> 16;
        ra = x;
        rb = -hf + s;
        rc = -hf - s;
        mx = ra; if (rb > mx) mx = rb; if (rc > mx) mx = rc;
        mn = ra; if (rb < mn) mn = rb; if (rc < mn) mn = rc;
        off = -((mx + mn) >>> 1);
        ca = ra + off;
        cb = rb + off;
        cc = rc + off;
        maxabs = magnitude(ca);
        if (magnitude(cb) > maxabs) maxabs = magnitude(cb);
        if (magnitude(cc) > maxabs) maxabs = magnitude(cc);
        if (maxabs == 0) maxabs = 1;
        num = (longint'(limit) * vdc) << 12;
        scale = (num >= maxabs * 32768) ? 32768 : num / maxabs;
        e.duty_a = phase_duty(ca, scale, vdc);
        e.duty_b = phase_duty(cb, scale, vdc);
        e.duty_c = phase_duty(cc, scale, vdc);
        e.scale  = 16'(scale);
        pending_duties.push_back(e);
    endfunction

    function void check_result(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic [15:0] sc);
        duty_beat_t e;
        if (pending_duties.size() == 0) begin
            $error("result beat with no expected duties");
            errors++;
            return;
        end
        e = pending_duties.pop_front();
        checked++;
        if (a !== e.duty_a) begin
            $error("duty_a expected %0d actual %0d", e.duty_a, a); errors++;
        end
        if (b !== e.duty_b) begin
            $error("duty_b expected %0d actual %0d", e.duty_b, b); errors++;
        end
        if (c !== e.duty_c) begin
            $error("duty_c expected %0d actual %0d", e.duty_c, c); errors++;
        end
        if (sc !== e.scale) begin
            $error("phase_gain expected %0d actual %0d", e.scale, sc); errors++;
        end
    endfunction

endclass

module testbench;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_bus_voltage = '0;
    logic signed [15:0] s_d_voltage_ref = '0;
    logic signed [15:0] s_q_voltage_ref = '0;
    logic [15:0]        s_electrical_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_duty_a;
    logic [15:0]        m_duty_b;
    logic [15:0]        m_duty_c;
    logic [15:0]        m_phase_gain;

    duty_scoreboard sb = new();
    longint         cycles = 0;
    int             beats_sent = 0;
    int             limits_used = 1;

    svpwm_duty_calculator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_bus_voltage(s_bus_voltage), .s_d_voltage_ref(s_d_voltage_ref),
        .s_q_voltage_ref(s_q_voltage_ref), .s_electrical_angle(s_electrical_angle),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_duty_a(m_duty_a), .m_duty_b(m_duty_b), .m_duty_c(m_duty_c),
        .m_phase_gain(m_phase_gain)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // result side stalls
    always @(negedge aclk) begin
        static int hold = 0;
        static bit calm = 0;
        if (hold > 0) begin
            hold--;
        end else begin
            calm = ($urandom_range(0, 9) == 0);
            if (m_ready && !calm) begin
                m_ready <= 1'b0;
                hold = idle_len();
            end else begin
                m_ready <= 1'b1;
                hold = calm ? $urandom_range(50, 200) : $urandom_range(0, 12);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_duty_a, m_duty_b, m_duty_c, m_phase_gain);
    end

    task automatic send_beat(logic signed [15:0] bus, logic signed [15:0] d,
                             logic signed [15:0] q, logic [15:0] ang);
        int g;
        g = idle_len();
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_bus_voltage      <= bus;
        s_d_voltage_ref    <= d;
        s_q_voltage_ref    <= q;
        s_electrical_angle <= ang;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(bus, d, q, ang);
        beats_sent++;
    endtask

    task automatic drain_and_set_limit(logic [15:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_duties.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.limit = v;
        limits_used++;
    endtask

    task automatic random_beats(int n);
        logic signed [15:0] bus, d, q;
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                bus = 16'($urandom_range(640, 32767));
                d   = 16'($urandom_range(0, 2 * bus) - bus);
                q   = 16'($urandom_range(0, 2 * bus) - bus);
            end else if (kind < 8) begin
                bus = 16'($urandom);
                d   = 16'($urandom);
                q   = 16'($urandom);
            end else begin
                bus = 16'($urandom_range(0, 130) - 65);
                d   = 16'($urandom_range(0, 400) - 200);
                q   = 16'($urandom_range(0, 400) - 200);
            end
            send_beat(bus, d, q, 16'($urandom));
        end
    endtask

    initial begin
        logic [15:0] limits[7];
        limits = '{16'd0, 16'd32768, 16'd65535, 16'd1, 16'd28377, 16'd18919, 16'd0};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, quadrant edges, zero and tiny bus, zero command
        send_beat(16'sd32767, 16'sd32767, 16'sd32767, 16'd0);
        send_beat(-16'sd32768, -16'sd32768, -16'sd32768, 16'd65535);
        send_beat(16'sd0, 16'sd1000, 16'sd0, 16'd16384);
        send_beat(16'sd63, 16'sd0, 16'sd500, 16'd32768);
        send_beat(-16'sd64, 16'sd300, -16'sd300, 16'd49152);
        send_beat(16'sd1, 16'sd0, 16'sd0, 16'd8192);
        send_beat(16'sd19200, 16'sd0, 16'sd0, 16'd57344);
        send_beat(16'sd19200, 16'sd5000, 16'sd2000, 16'd8191);
        send_beat(16'sd19200, -16'sd6000, 16'sd9000, 16'd24576);
        send_beat(16'sd19200, 16'sd32767, -16'sd32768, 16'd40960);
        send_beat(-16'sd19200, 16'sd4000, 16'sd4000, 16'd12345);
        send_beat(16'sd3200, 16'sd3200, 16'sd0, 16'd0);
        send_beat(16'sd3200, 16'sd0, 16'sd3200, 16'd21845);
        random_beats(200);
        foreach (limits[k]) begin
            drain_and_set_limit(limits[k]);
            send_beat(16'sd0, 16'sd0, 16'sd0, 16'd0);
            send_beat(16'sd32767, 16'sd32767, 16'sd32767, 16'd8192);
            random_beats(170);
        end
        drain_and_set_limit(16'($urandom));
        random_beats(60);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_duties.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d beats and checked %0d results over %0d limit settings",
                 beats_sent, sb.checked, limits_used);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
